/* src/srr_pkg.sv */
package srr_pkg;

	localparam int SEQ_W       = 8;
	localparam int LEN_W       = 10;
	localparam int TIME_W      = 16;
	localparam int CNT_W       = 5;
	localparam int ADV_W       = 5;
	localparam int MAX_RESULTS = 32;
	localparam int BATCH_MAX   = 31;

	typedef enum logic [1:0] {
		KIND_DELIVER = 2'd0,
		KIND_ACK     = 2'd1,
		KIND_NACK    = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		CFG_WINDOW = 2'd0,
		CFG_BATCH  = 2'd1,
		CFG_DELAY  = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ALU_SUB_SEQ  = 2'd0,
		ALU_SUB_TIME = 2'd1,
		ALU_GT       = 2'd2
	} alu_op_t;

	typedef struct packed {
		logic [ADV_W-1:0]  window;
		logic [CNT_W-1:0]  batch_limit;
		logic [TIME_W-1:0] delay;
	} cfg_t;

	typedef struct packed {
		logic              ok;
		logic [SEQ_W-1:0]  seq;
		logic              tr;
		logic [LEN_W-1:0]  len;
		logic [TIME_W-1:0] now;
	} item_t;

	typedef struct packed {
		kind_t             kind;
		logic [SEQ_W-1:0]  seq;
		logic [ADV_W-1:0]  advert;
		logic [LEN_W-1:0]  len;
		logic              last;
		logic              finished;
	} res_t;

endpackage

/* src/srr_ram.sv */
module srr_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/srr_alu.sv */
module srr_alu import srr_pkg::*; #(
	parameter int SEQ_SPACE = 256
) (
	input  alu_op_t           op,
	input  logic [TIME_W-1:0] a,
	input  logic [TIME_W-1:0] b,
	output logic [TIME_W-1:0] res,
	output logic              flag
);

	logic [TIME_W:0] diff;

	assign diff = {1'b0, a} - {1'b0, b};

	always_comb begin
		res  = '0;
		flag = 1'b0;
		unique case (op)
			ALU_SUB_SEQ: begin
				// wrap back into the sequence space on borrow
				res = diff[TIME_W] ? diff[TIME_W-1:0] + TIME_W'(SEQ_SPACE) : diff[TIME_W-1:0];
			end
			ALU_SUB_TIME: begin
				res = diff[TIME_W-1:0];
			end
			ALU_GT: begin
				flag = !diff[TIME_W] && (|diff[TIME_W-1:0]);
			end
			default: begin
				res  = '0;
				flag = 1'b0;
			end
		endcase
	end

endmodule

/* src/srr_seq.sv */
module srr_seq import srr_pkg::*; #(
	parameter int SEQ_SPACE   = 256,
	parameter int SLOTS       = 32,
	parameter int MAX_PAYLOAD = 512
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t item,
	input  logic  out_free,
	output logic  push,
	output res_t  res
);

	localparam int IW = $clog2(SEQ_SPACE);
	localparam int HW = $clog2(SLOTS + 1);
	localparam int CW = (HW > ADV_W) ? HW : ADV_W;
	localparam int NW = $clog2(MAX_RESULTS);

	typedef enum logic [9:0] {
		S_IDLE    = 10'b00_0000_0001,
		S_MOD     = 10'b00_0000_0010,
		S_TSUB    = 10'b00_0000_0100,
		S_TCMP    = 10'b00_0000_1000,
		S_CHECK   = 10'b00_0001_0000,
		S_WIN     = 10'b00_0010_0000,
		S_NACK    = 10'b00_0100_0000,
		S_REL_RD  = 10'b00_1000_0000,
		S_REL_OUT = 10'b01_0000_0000,
		S_ACK     = 10'b10_0000_0000
	} state_t;

	state_t              state_q;
	item_t               item_q;
	logic [IW-1:0]       nxt_q;
	logic [SEQ_SPACE-1:0] map_q;
	logic [HW-1:0]       held_q;
	logic [CNT_W-1:0]    batch_q;
	logic [TIME_W-1:0]   start_q;
	logic                restart_q;
	logic [1:0]          dsat_q;
	logic                eof_v_q;
	logic [IW-1:0]       eof_seq_q;
	logic [TIME_W-1:0]   diff_q;
	logic                late_q;
	logic                force_q;
	logic [IW-1:0]       offset_q;
	logic [NW-1:0]       n_q;

	alu_op_t           alu_op;
	logic [TIME_W-1:0] alu_a;
	logic [TIME_W-1:0] alu_b;
	logic [TIME_W-1:0] alu_res;
	logic              alu_flag;

	logic [IW-1:0]    seq_idx;
	logic [IW-1:0]    nxt_inc;
	logic             seq_big;
	logic             bad;
	logic             dup;
	logic             more;
	logic [1:0]       dsat_inc;
	logic             batch_ge;
	logic             timing_ack;
	logic             ack_after_del;
	logic             ack_due;
	logic             held_full;
	logic [CW-1:0]    win_ext;
	logic [CW-1:0]    held_ext;
	logic [ADV_W-1:0] advert;
	logic             finished;

	logic             ram_we;
	logic             ram_re;
	logic [IW-1:0]    ram_raddr;
	logic [LEN_W-1:0] ram_rdata;

	srr_alu #(.SEQ_SPACE(SEQ_SPACE)) u_alu (
		.op   (alu_op),
		.a    (alu_a),
		.b    (alu_b),
		.res  (alu_res),
		.flag (alu_flag)
	);

	// payload length per sequence number, valid only where map_q is set
	srr_ram #(.WIDTH(LEN_W), .DEPTH(SEQ_SPACE)) u_len_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (seq_idx),
		.wdata (item_q.len),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign seq_idx    = item_q.seq[IW-1:0];
	assign nxt_inc    = (nxt_q == IW'(SEQ_SPACE - 1)) ? '0 : nxt_q + 1'b1;
	assign seq_big    = {1'b0, item_q.seq} >= (SEQ_W+1)'(SEQ_SPACE);
	assign bad        = !item_q.ok || ({1'b0, item_q.len} > (LEN_W+1)'(MAX_PAYLOAD));
	assign dup        = map_q[seq_idx];
	assign more       = (n_q != NW'(MAX_RESULTS - 2)) && map_q[nxt_inc];
	assign dsat_inc   = (dsat_q == 2'd3) ? 2'd3 : dsat_q + 2'd1;
	assign batch_ge   = batch_q >= cfg.batch_limit;
	assign timing_ack = late_q || batch_ge || force_q;
	// a first delivery forces an ack, so the last delivery knows whether one follows
	assign ack_after_del = timing_ack || (dsat_inc == 2'd1);
	assign ack_due    = timing_ack || (dsat_q == 2'd1);
	assign held_full  = held_q == HW'(SLOTS);
	assign win_ext    = CW'(cfg.window);
	assign held_ext   = CW'(held_q);
	assign advert     = (win_ext > held_ext) ? ADV_W'(win_ext - held_ext) : '0;
	assign finished   = eof_v_q && (eof_seq_q == nxt_q);
	assign in_ready   = state_q == S_IDLE;

	always_comb begin
		alu_op = ALU_GT;
		alu_a  = '0;
		alu_b  = '0;
		unique case (state_q)
			S_TSUB: begin
				alu_op = ALU_SUB_TIME;
				alu_a  = item_q.now;
				alu_b  = start_q;
			end
			S_TCMP: begin
				alu_op = ALU_GT;
				alu_a  = diff_q;
				alu_b  = cfg.delay;
			end
			S_CHECK: begin
				alu_op = ALU_SUB_SEQ;
				alu_a  = TIME_W'(seq_idx);
				alu_b  = TIME_W'(nxt_q);
			end
			S_WIN: begin
				alu_op = ALU_GT;
				alu_a  = TIME_W'(cfg.window);
				alu_b  = TIME_W'(offset_q);
			end
			default: begin
				alu_op = ALU_GT;
			end
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = nxt_q;
		push      = 1'b0;
		res       = '{kind: KIND_ACK, seq: SEQ_W'(nxt_q), advert: advert, len: '0,
			last: 1'b1, finished: finished};
		unique case (state_q)
			S_WIN: begin
				ram_we = alu_flag && !item_q.tr && (item_q.len != '0) && !held_full;
			end
			S_REL_RD: begin
				ram_re = map_q[nxt_q];
			end
			S_REL_OUT: begin
				push      = out_free;
				ram_re    = out_free && more;
				ram_raddr = nxt_inc;
				res       = '{kind: KIND_DELIVER, seq: SEQ_W'(nxt_q), advert: '0,
					len: ram_rdata, last: !more && !ack_after_del, finished: 1'b0};
			end
			S_NACK: begin
				push = out_free;
				res  = '{kind: KIND_NACK, seq: SEQ_W'(seq_idx), advert: advert, len: '0,
					last: 1'b1, finished: 1'b0};
			end
			S_ACK: begin
				push = ack_due && out_free;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			item_q <= item;
		end else if (state_q == S_MOD && seq_big) begin
			item_q.seq <= item_q.seq - SEQ_W'(SEQ_SPACE);
		end
		if (state_q == S_TSUB) begin
			diff_q <= alu_res;
		end
		if (state_q == S_CHECK) begin
			offset_q <= alu_res[IW-1:0];
		end
		if (state_q == S_WIN && alu_flag && !item_q.tr && item_q.len == '0 &&
			offset_q == '0) begin
			eof_seq_q <= seq_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			nxt_q     <= '0;
			map_q     <= '0;
			held_q    <= '0;
			batch_q   <= '0;
			start_q   <= '0;
			restart_q <= 1'b1;
			dsat_q    <= 2'd0;
			eof_v_q   <= 1'b0;
			late_q    <= 1'b0;
			force_q   <= 1'b0;
			n_q       <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						force_q <= 1'b0;
						n_q     <= '0;
						if (restart_q) begin
							start_q   <= item.now;
							restart_q <= 1'b0;
						end
						if (batch_q != CNT_W'(BATCH_MAX)) begin
							batch_q <= batch_q + 1'b1;
						end
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (!seq_big) begin
						state_q <= S_TSUB;
					end
				end
				S_TSUB: begin
					state_q <= S_TCMP;
				end
				S_TCMP: begin
					late_q  <= alu_flag;
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (bad || dup) begin
						force_q <= 1'b1;
						state_q <= S_ACK;
					end else begin
						state_q <= S_WIN;
					end
				end
				S_WIN: begin
					if (!alu_flag) begin
						state_q <= S_ACK;
					end else if (item_q.tr) begin
						state_q <= S_NACK;
					end else if (item_q.len == '0) begin
						// end of file only at the expected number
						if (offset_q == '0) begin
							eof_v_q <= 1'b1;
							force_q <= 1'b1;
						end
						state_q <= S_ACK;
					end else if (held_full) begin
						state_q <= S_ACK;
					end else begin
						map_q[seq_idx] <= 1'b1;
						held_q         <= held_q + 1'b1;
						state_q        <= S_REL_RD;
					end
				end
				S_NACK: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_REL_RD: begin
					state_q <= map_q[nxt_q] ? S_REL_OUT : S_ACK;
				end
				S_REL_OUT: begin
					if (out_free) begin
						map_q[nxt_q] <= 1'b0;
						held_q       <= held_q - 1'b1;
						nxt_q        <= nxt_inc;
						dsat_q       <= dsat_inc;
						n_q          <= n_q + 1'b1;
						state_q      <= more ? S_REL_OUT : S_ACK;
					end
				end
				S_ACK: begin
					if (!ack_due) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						batch_q   <= '0;
						restart_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_held_matches_map: assert property (@(posedge clk) disable iff (!arst_n)
		held_q == HW'($countones(map_q)))
		else $error("held count out of step with held map");

	a_push_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("result pushed into a full output register");

	a_dsat_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		dsat_q != 2'd0 |=> dsat_q != 2'd0)
		else $error("delivery count went back to zero");

	a_eof_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		eof_v_q |=> eof_v_q)
		else $error("end of file mark lost");

endmodule

/* src/selective_repeat_receiver_top.sv */
// Receiver side of a selective-repeat scheme with a reorder window.
// Input channel (in_valid/in_ready) takes one decoded packet per beat:
// packet_ok, seqnum, truncated, payload_length, arrival_ms.
// Output channel (out_valid/out_ready) gives result beats: in-order
// deliveries (kind 0), a cumulative ack (kind 1) or a nack (kind 2);
// last marks the final beat caused by a packet, and a packet may cause none.
// The user writes configuration through cfg_we/cfg_index/cfg_data only
// while idle; the block does not enforce it. One packet is worked on at
// a time by a sequencer around one shared subtract/compare unit: a run
// of checks, then the release of each in-order held packet.
// in_ready is high only between packets. The single output register lets
// the sequencer run while a beat waits; when out_ready stays low the
// sequencer stalls on the next beat it must emit.
// Reset clears the window, held map, batch timer and end-of-file mark and
// restores window_size 31, ack_batch_limit 7, ack_delay_ms 500.
module selective_repeat_receiver_top import srr_pkg::*; #(
	parameter int SEQ_SPACE   = 256,
	parameter int SLOTS       = 32,
	parameter int MAX_PAYLOAD = 512
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [TIME_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              packet_ok,
	input  logic [SEQ_W-1:0]  seqnum,
	input  logic              truncated,
	input  logic [LEN_W-1:0]  payload_length,
	input  logic [TIME_W-1:0] arrival_ms,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        kind,
	output logic [SEQ_W-1:0]  out_seqnum,
	output logic [ADV_W-1:0]  window_advert,
	output logic [LEN_W-1:0]  out_length,
	output logic              last,
	output logic              finished
);

	cfg_t  cfg_q;
	res_t  res_q;
	logic  out_valid_q;
	res_t  res;
	logic  push;
	logic  out_free;
	item_t item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window      <= ADV_W'(31);
			cfg_q.batch_limit <= CNT_W'(7);
			cfg_q.delay       <= TIME_W'(500);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WINDOW: cfg_q.window      <= cfg_data[ADV_W-1:0];
				CFG_BATCH:  cfg_q.batch_limit <= cfg_data[CNT_W-1:0];
				CFG_DELAY:  cfg_q.delay       <= cfg_data;
				default:    cfg_q             <= cfg_q;
			endcase
		end
	end

	assign item = '{ok: packet_ok, seq: seqnum, tr: truncated, len: payload_length,
		now: arrival_ms};

	srr_seq #(
		.SEQ_SPACE   (SEQ_SPACE),
		.SLOTS       (SLOTS),
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.item     (item),
		.out_free (out_free),
		.push     (push),
		.res      (res)
	);

	// output register decouples the sequencer from the consumer
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = res_q.kind;
	assign out_seqnum    = res_q.seq;
	assign window_advert = res_q.advert;
	assign out_length    = res_q.len;
	assign last          = res_q.last;
	assign finished      = res_q.finished;

endmodule
